// ===== design/dmepid_pkg.sv =====
// Shared types and constants for the dual-motor encoder PID speed unit.
// Used by dmepid_lane, dmepid_merge and the top level; depends on nothing.
package dmepid_pkg;

  localparam int GAIN_W     = 16;
  localparam int TARGET_W   = 10;
  localparam int SPEED_W    = 12;
  localparam int ERR_W      = 13;
  localparam int DIFF_W     = 14;
  localparam int INTEG_W    = 8;
  localparam int INTEG_SUM_W = 14;
  localparam int SUM_W      = 32;
  localparam int PWM_W      = 8;

  localparam int SPEED_LIMIT = 2047;
  localparam int INTEG_LIMIT = 100;
  localparam int OUT_LIMIT   = 255;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Request codes carried in req_type.
  localparam logic REQ_PIN  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [2:0] {
    REG_PROP_A   = 3'd0,
    REG_INTEG_A  = 3'd1,
    REG_DERIV_A  = 3'd2,
    REG_PROP_B   = 3'd3,
    REG_INTEG_B  = 3'd4,
    REG_DERIV_B  = 3'd5,
    REG_ENABLE   = 3'd6
  } reg_idx_t;

  // Quadrature step indexed by {prev A, prev B, new A, new B}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } gain_set_t;

  typedef struct packed {
    logic pin_en;
    logic tick_en;
    logic ld_s2;
  } lane_ctrl_t;

  typedef struct packed {
    logic [PWM_W-1:0] mag;
    logic             neg;
  } lane_res_t;

endpackage

// ===== design/dmepid_lane.sv =====
// One motor's lane: encoder decode, position count, speed measurement and PID.
// Depends on dmepid_pkg.
module dmepid_lane #(
  parameter int POSITION_WIDTH = 32,
  parameter int FRAC_BITS      = 8,
  parameter bit REVERSE_COUNT  = 1'b0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dmepid_pkg::lane_ctrl_t                 ctrl,
  input  logic                                   phase_a,
  input  logic                                   phase_b,
  input  logic signed [dmepid_pkg::TARGET_W-1:0] target,
  input  dmepid_pkg::gain_set_t                  gains,
  output dmepid_pkg::lane_res_t                  res
);
  import dmepid_pkg::*;

  logic [3:0]                       hist_r, hist_nxt;
  logic [POSITION_WIDTH-1:0]        pos_r, pos_nxt, prev_pos_r;
  logic signed [1:0]                step;
  logic signed [POSITION_WIDTH-1:0] delta;
  logic signed [SPEED_W-1:0]        speed;
  logic signed [ERR_W-1:0]          err, prev_err_r;
  logic signed [INTEG_SUM_W-1:0]    integ_sum;
  logic signed [INTEG_W-1:0]        integ_r, integ_nxt;
  logic signed [DIFF_W-1:0]         diff;

  logic signed [ERR_W-1:0]          err_s1_r;
  logic signed [INTEG_W-1:0]        integ_s1_r;
  logic signed [DIFF_W-1:0]         diff_s1_r;

  logic signed [GAIN_W+ERR_W-1:0]   prop_prod_r;
  logic signed [GAIN_W+INTEG_W-1:0] integ_prod_r;
  logic signed [GAIN_W+DIFF_W-1:0]  deriv_prod_r;

  logic signed [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]                 sum_abs, sum_shr;

  // Encoder history and position step.
  always_comb begin
    hist_nxt = {hist_r[1:0], phase_a, phase_b};
    step     = STEP_TABLE[hist_nxt];
    pos_nxt  = pos_r + {{(POSITION_WIDTH-2){step[1]}}, step};
  end

  // Speed, error, clamped integral and difference for a tick.
  always_comb begin
    if (REVERSE_COUNT) begin
      delta = prev_pos_r - pos_r;
    end else begin
      delta = pos_r - prev_pos_r;
    end
    if (delta > POSITION_WIDTH'(SPEED_LIMIT)) begin
      speed = SPEED_W'(SPEED_LIMIT);
    end else if (delta < POSITION_WIDTH'(-SPEED_LIMIT)) begin
      speed = SPEED_W'(-SPEED_LIMIT);
    end else begin
      speed = delta[SPEED_W-1:0];
    end
    err       = ERR_W'(target) - ERR_W'(speed);
    integ_sum = INTEG_SUM_W'(integ_r) + INTEG_SUM_W'(err);
    if (integ_sum > INTEG_SUM_W'(INTEG_LIMIT)) begin
      integ_nxt = INTEG_W'(INTEG_LIMIT);
    end else if (integ_sum < INTEG_SUM_W'(-INTEG_LIMIT)) begin
      integ_nxt = INTEG_W'(-INTEG_LIMIT);
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end
    diff = DIFF_W'(err) - DIFF_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= '0;
      pos_r      <= '0;
      prev_pos_r <= '0;
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (ctrl.pin_en) begin
        hist_r <= hist_nxt;
        pos_r  <= pos_nxt;
      end
      if (ctrl.tick_en) begin
        prev_pos_r <= pos_r;
        integ_r    <= integ_nxt;
        prev_err_r <= err;
      end
    end
  end

  // Stage 1 holds the PID terms, stage 2 the three products.
  always_ff @(posedge clk) begin
    if (ctrl.tick_en) begin
      err_s1_r   <= err;
      integ_s1_r <= integ_nxt;
      diff_s1_r  <= diff;
    end
    if (ctrl.ld_s2) begin
      prop_prod_r  <= gains.prop * err_s1_r;
      integ_prod_r <= gains.integ * integ_s1_r;
      deriv_prod_r <= gains.deriv * diff_s1_r;
    end
  end

  // Sum, truncate toward zero by magnitude shift, clamp.
  always_comb begin
    sum     = SUM_W'(prop_prod_r) + SUM_W'(integ_prod_r) + SUM_W'(deriv_prod_r);
    sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    sum_shr = sum_abs >> FRAC_BITS;
    res.neg = sum[SUM_W-1];
    if (sum_shr > SUM_W'(OUT_LIMIT)) begin
      res.mag = PWM_W'(OUT_LIMIT);
    end else begin
      res.mag = sum_shr[PWM_W-1:0];
    end
  end

endmodule

// ===== design/dmepid_merge.sv =====
// Output stage: merges both lanes' results into the result register, applies
// the drive enable and keeps each motor's held direction. Depends on dmepid_pkg.
module dmepid_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ld,
  input  logic                             drive_enable,
  input  dmepid_pkg::lane_res_t            res_a,
  input  dmepid_pkg::lane_res_t            res_b,
  output logic [dmepid_pkg::PWM_W-1:0]     pwm_a,
  output logic                             dir_a,
  output logic [dmepid_pkg::PWM_W-1:0]     pwm_b,
  output logic                             dir_b
);
  import dmepid_pkg::*;

  logic             held_a_r, held_a_nxt, held_b_r, held_b_nxt;
  logic [PWM_W-1:0] pwm_a_r, pwm_b_r;
  logic             dir_a_r, dir_b_r;

  // While disabled the held direction stays and is reported as is.
  always_comb begin
    held_a_nxt = drive_enable ? res_a.neg : held_a_r;
    held_b_nxt = drive_enable ? res_b.neg : held_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_a_r <= 1'b0;
      held_b_r <= 1'b0;
    end else if (ld) begin
      held_a_r <= held_a_nxt;
      held_b_r <= held_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      pwm_a_r <= drive_enable ? res_a.mag : '0;
      pwm_b_r <= drive_enable ? res_b.mag : '0;
      dir_a_r <= held_a_nxt;
      dir_b_r <= held_b_nxt;
    end
  end

  assign pwm_a = pwm_a_r;
  assign pwm_b = pwm_b_r;
  assign dir_a = dir_a_r;
  assign dir_b = dir_b_r;

endmodule

// ===== design/dual_motor_encoder_pid_speed_unit.sv =====
// Dual-motor encoder PID speed unit, top level: APB register file, two motor lanes, merge stage.
// Depends on dmepid_pkg, dmepid_lane and dmepid_merge.
// A tick transaction moves through stage 1, stage 2 and the result register in turn.
// Throughput: one transaction per cycle, pin samples and ticks alike, limited by nothing but
// the result register's back-pressure through the two-stage PID pipeline.
// Reset (rst_n, synchronous, active low): positions, histories, PID state and held
// directions clear, gains return to their defaults and the drive is disabled.
module dual_motor_encoder_pid_speed_unit #(
  parameter int POSITION_WIDTH     = 32,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input channel.
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_req_type,
  input  logic                                    in_enc_a_phase_a,
  input  logic                                    in_enc_a_phase_b,
  input  logic                                    in_enc_b_phase_a,
  input  logic                                    in_enc_b_phase_b,
  input  logic signed [dmepid_pkg::TARGET_W-1:0]  in_target_speed_a,
  input  logic signed [dmepid_pkg::TARGET_W-1:0]  in_target_speed_b,
  // Result channel.
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [dmepid_pkg::PWM_W-1:0]            out_pwm_a,
  output logic                                    out_dir_a,
  output logic [dmepid_pkg::PWM_W-1:0]            out_pwm_b,
  output logic                                    out_dir_b,
  // APB configuration port.
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [dmepid_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [dmepid_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [dmepid_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                    pready
);
  import dmepid_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands in the access phase; pready is tied
  // high so every transaction completes without wait states.
  // ---------------------------------------------------------------------------
  gain_set_t gains_a_r, gains_b_r;
  logic      drive_enable_r;
  reg_idx_t  reg_idx;
  logic      cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_a_r.prop  <= GAIN_W'(1536);
      gains_a_r.integ <= GAIN_W'(461);
      gains_a_r.deriv <= '0;
      gains_b_r.prop  <= GAIN_W'(1536);
      gains_b_r.integ <= GAIN_W'(461);
      gains_b_r.deriv <= '0;
      drive_enable_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PROP_A:  gains_a_r.prop  <= pwdata[GAIN_W-1:0];
        REG_INTEG_A: gains_a_r.integ <= pwdata[GAIN_W-1:0];
        REG_DERIV_A: gains_a_r.deriv <= pwdata[GAIN_W-1:0];
        REG_PROP_B:  gains_b_r.prop  <= pwdata[GAIN_W-1:0];
        REG_INTEG_B: gains_b_r.integ <= pwdata[GAIN_W-1:0];
        REG_DERIV_B: gains_b_r.deriv <= pwdata[GAIN_W-1:0];
        REG_ENABLE:  drive_enable_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Reads return the register zero-extended; unused addresses read zero.
  always_comb begin
    unique case (reg_idx)
      REG_PROP_A:  prdata = CFG_DATA_W'(unsigned'(gains_a_r.prop));
      REG_INTEG_A: prdata = CFG_DATA_W'(unsigned'(gains_a_r.integ));
      REG_DERIV_A: prdata = CFG_DATA_W'(unsigned'(gains_a_r.deriv));
      REG_PROP_B:  prdata = CFG_DATA_W'(unsigned'(gains_b_r.prop));
      REG_INTEG_B: prdata = CFG_DATA_W'(unsigned'(gains_b_r.integ));
      REG_DERIV_B: prdata = CFG_DATA_W'(unsigned'(gains_b_r.deriv));
      REG_ENABLE:  prdata = CFG_DATA_W'(drive_enable_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the PID terms, stage 2 the products and the
  // result register sits after the merge. Each stage advances when the next is
  // empty or moving, so new transactions keep flowing while a result waits, until the pipeline fills.
  // Pin samples update the position counters at acceptance and leave no trace
  // in the pipeline.
  // ---------------------------------------------------------------------------
  logic       s1_v_r, s2_v_r, out_v_r;
  logic       move2, move3, s2_free, in_acc;
  lane_ctrl_t lane_ctrl;

  always_comb begin
    move3    = s2_v_r && (!out_v_r || out_ready);
    s2_free  = !s2_v_r || move3;
    move2    = s1_v_r && s2_free;
    in_ready = !s1_v_r || move2;
    in_acc   = in_valid && in_ready;
    lane_ctrl.pin_en  = in_acc && (in_req_type == REQ_PIN);
    lane_ctrl.tick_en = in_acc && (in_req_type == REQ_TICK);
    lane_ctrl.ld_s2   = move2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= lane_ctrl.tick_en || (s1_v_r && !move2);
      s2_v_r  <= move2 || (s2_v_r && !move3);
      out_v_r <= move3 || (out_v_r && !out_ready);
    end
  end

  assign out_valid = out_v_r;

  // ---------------------------------------------------------------------------
  // Motor lanes. Motor A counts the other way, so its speed is negated.
  // ---------------------------------------------------------------------------
  lane_res_t res_a, res_b;

  dmepid_lane #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .FRAC_BITS      (GAIN_FRACTION_BITS),
    .REVERSE_COUNT  (1'b1)
  ) u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .phase_a (in_enc_a_phase_a),
    .phase_b (in_enc_a_phase_b),
    .target  (in_target_speed_a),
    .gains   (gains_a_r),
    .res     (res_a)
  );

  dmepid_lane #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .FRAC_BITS      (GAIN_FRACTION_BITS),
    .REVERSE_COUNT  (1'b0)
  ) u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .phase_a (in_enc_b_phase_a),
    .phase_b (in_enc_b_phase_b),
    .target  (in_target_speed_b),
    .gains   (gains_b_r),
    .res     (res_b)
  );

  // Merge both lanes into one result transaction.
  dmepid_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld           (move3),
    .drive_enable (drive_enable_r),
    .res_a        (res_a),
    .res_b        (res_b),
    .pwm_a        (out_pwm_a),
    .dir_a        (out_dir_a),
    .pwm_b        (out_pwm_b),
    .dir_b        (out_dir_b)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctrl.tick_en |=> s1_v_r)
    else $error("accepted tick did not enter stage 1");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_v_r && !out_ready) |=> s2_v_r)
    else $error("stalled stage 2 lost its transaction");

  a_pin_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_ctrl.pin_en && !s1_v_r) |=> !s1_v_r)
    else $error("pin sample created a pipeline entry");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (move3 && !drive_enable_r) |=> (out_pwm_a == '0 && out_pwm_b == '0))
    else $error("nonzero PWM while drive disabled");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for dual_motor_encoder_pid_speed_unit: encoder sample and control tick
// transactions go in, drive commands are predicted in-line and checked. Depends on dmepid_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmepid_pkg::*;

  localparam int POS_W     = 32;
  localparam int FRAC_BITS = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  // One input transaction as the sender sees it. Encoder levels are kept as
  // {channel A, channel B} pairs per motor.
  typedef struct {
    logic                       req_type;
    logic [1:0]                 lvl_a;
    logic [1:0]                 lvl_b;
    logic signed [TARGET_W-1:0] tgt_a;
    logic signed [TARGET_W-1:0] tgt_b;
  } speed_req_t;

  // One drive command, the result of a control tick.
  typedef struct packed {
    logic [PWM_W-1:0] pwm_a;
    logic             dir_a;
    logic [PWM_W-1:0] pwm_b;
    logic             dir_b;
  } drive_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_req_type = 1'b0;
  logic                       in_enc_a_phase_a = 1'b0;
  logic                       in_enc_a_phase_b = 1'b0;
  logic                       in_enc_b_phase_a = 1'b0;
  logic                       in_enc_b_phase_b = 1'b0;
  logic signed [TARGET_W-1:0] in_target_speed_a = '0;
  logic signed [TARGET_W-1:0] in_target_speed_b = '0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [PWM_W-1:0]           out_pwm_a;
  logic                       out_dir_a;
  logic [PWM_W-1:0]           out_pwm_b;
  logic                       out_dir_b;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  dual_motor_encoder_pid_speed_unit #(
    .POSITION_WIDTH(POS_W),
    .GAIN_FRACTION_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_enc_a_phase_a(in_enc_a_phase_a),
    .in_enc_a_phase_b(in_enc_a_phase_b),
    .in_enc_b_phase_a(in_enc_b_phase_a),
    .in_enc_b_phase_b(in_enc_b_phase_b),
    .in_target_speed_a(in_target_speed_a),
    .in_target_speed_b(in_target_speed_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pwm_a(out_pwm_a),
    .out_dir_a(out_dir_a),
    .out_pwm_b(out_pwm_b),
    .out_dir_b(out_dir_b),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a transaction never completes.
  initial begin
    #4_000_000;
    $display("dual_motor_encoder_pid_speed_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Speed regulator model. Index 0 is motor A, index 1 is motor B.
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] kp [2];
  logic signed [GAIN_W-1:0] ki [2];
  logic signed [GAIN_W-1:0] kd [2];
  logic                     drive_on;

  logic [1:0]       levels_seen [2];
  logic [POS_W-1:0] pos_cnt [2];
  logic [POS_W-1:0] pos_at_tick [2];
  int               integ_acc [2];
  int               err_last [2];
  logic             dir_held [2];

  drive_cmd_t expected_cmds [$];
  speed_req_t pending_reqs [$];
  speed_req_t on_wire;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cmd_seen = 0;

  // Walk state of the stimulus generator: quadrature position of each encoder.
  logic [1:0] walk_rank [2];
  int         bias [2];

  // Gray code of a quadrature phase; the mapping is its own inverse.
  function automatic logic [1:0] gray_code(logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // Advancing one quadrature phase (00 -> 01 -> 11 -> 10) counts down, going
  // back counts up, a jump of two phases or no change counts nothing.
  function automatic int quad_step(logic [1:0] was, logic [1:0] now);
    logic [1:0] turn;
    turn = gray_code(now) - gray_code(was);
    if (turn == 2'd1) return -1;
    if (turn == 2'd3) return 1;
    return 0;
  endfunction

  // Counts per tick, read as a signed delta and saturated.
  function automatic int speed_of(logic [POS_W-1:0] delta);
    int s;
    s = $signed(delta);
    if (s > SPEED_LIMIT) return SPEED_LIMIT;
    if (s < -SPEED_LIMIT) return -SPEED_LIMIT;
    return s;
  endfunction

  function automatic void reset_model();
    for (int m = 0; m < 2; m++) begin
      kp[m] = 16'sd1536;
      ki[m] = 16'sd461;
      kd[m] = 16'sd0;
      levels_seen[m] = 2'b00;
      pos_cnt[m] = '0;
      pos_at_tick[m] = '0;
      integ_acc[m] = 0;
      err_last[m] = 0;
      dir_held[m] = 1'b0;
      walk_rank[m] = 2'b00;
    end
    drive_on = 1'b0;
  endfunction

  // PID update for one motor. The sum is exact; the shift truncates toward zero
  // and direction follows the sign of the exact sum, so a tiny negative sum
  // reports reverse with zero duty.
  task automatic pid_update(int m, int speed, int target, output logic [PWM_W-1:0] pwm,
                            output logic dir);
    int     err;
    int     acc;
    int     diff;
    longint sum;
    longint mag;
    err = target - speed;
    acc = integ_acc[m] + err;
    if (acc > INTEG_LIMIT) acc = INTEG_LIMIT;
    if (acc < -INTEG_LIMIT) acc = -INTEG_LIMIT;
    integ_acc[m] = acc;
    diff = err - err_last[m];
    err_last[m] = err;
    sum = longint'(kp[m]) * err + longint'(ki[m]) * acc + longint'(kd[m]) * diff;
    mag = (sum < 0) ? -sum : sum;
    mag = mag >> FRAC_BITS;
    if (mag > OUT_LIMIT) mag = OUT_LIMIT;
    if (drive_on) begin
      dir_held[m] = (sum < 0);
      pwm = mag[PWM_W-1:0];
    end else begin
      // Disabled drive: PID state moves on, duty is zero and the last
      // enabled direction is held.
      pwm = '0;
    end
    dir = dir_held[m];
  endtask

  // Applies one accepted transaction to the model.
  task automatic absorb_req(speed_req_t r);
    drive_cmd_t cmd;
    int         speed_a;
    int         speed_b;
    if (r.req_type == REQ_PIN) begin
      pos_cnt[0] += quad_step(levels_seen[0], r.lvl_a);
      pos_cnt[1] += quad_step(levels_seen[1], r.lvl_b);
      levels_seen[0] = r.lvl_a;
      levels_seen[1] = r.lvl_b;
    end else begin
      // Motor A is mounted mirrored, so its count runs backward.
      speed_a = speed_of(pos_at_tick[0] - pos_cnt[0]);
      speed_b = speed_of(pos_cnt[1] - pos_at_tick[1]);
      pos_at_tick[0] = pos_cnt[0];
      pos_at_tick[1] = pos_cnt[1];
      pid_update(0, speed_a, int'(r.tgt_a), cmd.pwm_a, cmd.dir_a);
      pid_update(1, speed_b, int'(r.tgt_b), cmd.pwm_b, cmd.dir_b);
      expected_cmds.push_back(cmd);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, holding each until its transaction
  // completes, and feeds every accepted one to the model.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_req(on_wire);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= on_wire.req_type;
          in_enc_a_phase_a <= on_wire.lvl_a[1];
          in_enc_a_phase_b <= on_wire.lvl_a[0];
          in_enc_b_phase_a <= on_wire.lvl_b[1];
          in_enc_b_phase_b <= on_wire.lvl_b[0];
          in_target_speed_a <= on_wire.tgt_a;
          in_target_speed_b <= on_wire.tgt_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure and in-order comparison of drive commands.
  // ---------------------------------------------------------------------------
  task automatic check_cmd();
    drive_cmd_t exp_cmd;
    logic       bad;
    if (expected_cmds.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected drive command pwm_a=%0d dir_a=%0d pwm_b=%0d dir_b=%0d",
                 out_pwm_a, out_dir_a, out_pwm_b, out_dir_b);
    end else begin
      exp_cmd = expected_cmds.pop_front();
      bad = (out_pwm_a !== exp_cmd.pwm_a) || (out_dir_a !== exp_cmd.dir_a) ||
            (out_pwm_b !== exp_cmd.pwm_b) || (out_dir_b !== exp_cmd.dir_b);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("drive command %0d: expected pwm_a=%0d dir_a=%0d pwm_b=%0d dir_b=%0d, %s",
                   cmd_seen, exp_cmd.pwm_a, exp_cmd.dir_a, exp_cmd.pwm_b, exp_cmd.dir_b,
                   $sformatf("got pwm_a=%0d dir_a=%0d pwm_b=%0d dir_b=%0d",
                             out_pwm_a, out_dir_a, out_pwm_b, out_dir_b));
      end
    end
    cmd_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_cmd();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register write over the APB port: setup cycle, access cycle, then release.
  // Only called while the block is idle, so the model is updated right away.
  // Indexes past the last register are ignored by the block.
  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROP_A:  kp[0] = val[GAIN_W-1:0];
      REG_INTEG_A: ki[0] = val[GAIN_W-1:0];
      REG_DERIV_A: kd[0] = val[GAIN_W-1:0];
      REG_PROP_B:  kp[1] = val[GAIN_W-1:0];
      REG_INTEG_B: ki[1] = val[GAIN_W-1:0];
      REG_DERIV_B: kd[1] = val[GAIN_W-1:0];
      REG_ENABLE:  drive_on = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Gain write with random upper bits, which the register must drop.
  task automatic write_gain(int idx, logic signed [GAIN_W-1:0] g);
    write_reg(idx, {16'($urandom), g});
  endtask

  task automatic write_enable(logic en);
    logic [CFG_DATA_W-1:0] v;
    v = $urandom;
    v[0] = en;
    write_reg(REG_ENABLE, v);
  endtask

  task automatic set_gains(logic signed [GAIN_W-1:0] p, logic signed [GAIN_W-1:0] i,
                           logic signed [GAIN_W-1:0] d);
    write_gain(REG_PROP_A, p);
    write_gain(REG_INTEG_A, i);
    write_gain(REG_DERIV_A, d);
    write_gain(REG_PROP_B, p);
    write_gain(REG_INTEG_B, i);
    write_gain(REG_DERIV_B, d);
  endtask

  // Pin sample; the target fields are don't-care and carry noise.
  task automatic push_pins(logic [1:0] la, logic [1:0] lb);
    speed_req_t r;
    r.req_type = REQ_PIN;
    r.lvl_a = la;
    r.lvl_b = lb;
    r.tgt_a = TARGET_W'($urandom);
    r.tgt_b = TARGET_W'($urandom);
    pending_reqs.push_back(r);
    walk_rank[0] = gray_code(la);
    walk_rank[1] = gray_code(lb);
  endtask

  // Control tick; the encoder fields are don't-care and carry noise.
  task automatic push_tick(int t_a, int t_b);
    speed_req_t r;
    r.req_type = REQ_TICK;
    r.lvl_a = 2'($urandom);
    r.lvl_b = 2'($urandom);
    r.tgt_a = TARGET_W'(t_a);
    r.tgt_b = TARGET_W'(t_b);
    pending_reqs.push_back(r);
  endtask

  // Target speeds: mostly in the range the encoders actually reach between
  // ticks, some anywhere, some at the field limits.
  function automatic int pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 60) return int'($urandom_range(80)) - 40;
    if (r < 85) return int'($urandom_range(1023)) - 512;
    return (r % 2 == 0) ? 511 : -512;
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 16'sh8000;
    if (r < 12) return 16'sh7FFF;
    if (r < 16) return 16'sh0000;
    if (r < 66) return GAIN_W'(int'($urandom_range(2048)) - 1024);
    return GAIN_W'($urandom);
  endfunction

  // One encoder sample per motor following the current bias: a legal step,
  // a hold, or now and then an arbitrary level pair.
  function automatic logic [1:0] walk_motor(int m);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 2'($urandom);
    if (r < 25) return gray_code(walk_rank[m]);
    if (bias[m] == 0) return gray_code(walk_rank[m] + ($urandom_range(1) ? 2'd1 : 2'd3));
    return gray_code(walk_rank[m] + 2'(bias[m]));
  endfunction

  // Mostly well-formed encoder motion with ticks mixed in.
  task automatic queue_mix(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        bias[0] = int'($urandom_range(2)) - 1;
        bias[1] = int'($urandom_range(2)) - 1;
      end
      if ($urandom_range(99) < 15) push_tick(pick_target(), pick_target());
      else push_pins(walk_motor(0), walk_motor(1));
    end
  endtask

  // Steady rotation of both encoders, one phase per sample.
  task automatic spin(int n, logic [1:0] stride);
    for (int i = 0; i < n; i++)
      push_pins(gray_code(walk_rank[0] + stride), gray_code(walk_rank[1] + stride));
  endtask

  // Waits until everything queued has been accepted and every drive command
  // has come back, then lets the pipeline run empty.
  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 49;

    // Drive disabled after reset: encoder motion is counted and the PID runs,
    // but duty stays zero. Includes an unchanged level pair and a double jump.
    push_pins(2'b00, 2'b00);
    push_pins(2'b01, 2'b10);
    push_pins(2'b11, 2'b11);
    push_pins(2'b11, 2'b11);
    push_tick(100, -100);
    push_pins(2'b00, 2'b00);
    push_tick(-512, 511);
    settle();

    // Default gains with the drive on: targets at the field limits drive the
    // integral and the output into their clamps.
    write_enable(1'b1);
    push_tick(511, -512);
    push_tick(0, 0);
    push_tick(-512, 511);
    settle();

    // Smallest proportional gain alone: a sum of -1 gives reverse with zero
    // duty, +1 forward with zero duty, and truncation goes toward zero.
    set_gains(16'sd1, 16'sd0, 16'sd0);
    push_tick(-1, 1);
    push_tick(-300, 300);
    settle();

    // Gains at their extremes, plus a write past the last register that must
    // leave every register alone.
    write_gain(REG_PROP_A, 16'sh8000);
    write_gain(REG_INTEG_A, 16'sh7FFF);
    write_gain(REG_DERIV_A, 16'sh8000);
    write_gain(REG_PROP_B, 16'sh7FFF);
    write_gain(REG_INTEG_B, 16'sh8000);
    write_gain(REG_DERIV_B, 16'sh7FFF);
    write_reg(int'(REG_ENABLE) + 1, 32'hFFFF_FFFF);
    push_pins(2'b01, 2'b01);
    push_tick(0, 0);
    push_tick(5, -5);
    settle();

    // Drive switched off again: the direction from the last enabled tick holds.
    write_enable(1'b0);
    push_tick(3, -3);
    settle();

    // Random phases, each with its own register setting. The idle pattern
    // moves from a slow receiver to a slow sender to no idling at all.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 11;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_gain(REG_PROP_A, pick_gain());
      write_gain(REG_INTEG_A, pick_gain());
      write_gain(REG_DERIV_A, pick_gain());
      write_gain(REG_PROP_B, pick_gain());
      write_gain(REG_INTEG_B, pick_gain());
      write_gain(REG_DERIV_B, pick_gain());
      write_enable($urandom_range(3) != 0);
      if (ph == 4) begin
        // The sender holds off until every drive command is back, then resumes.
        queue_mix(20);
        settle();
        queue_mix(25);
      end else begin
        queue_mix(45);
      end
      settle();
    end

    // Short runs of steady rotation in both directions. A tiny proportional
    // gain keeps the output clear of its clamp, so the measured speed shows
    // directly in the direction bits.
    set_gains(16'sd1, 16'sd0, 16'sd0);
    write_enable(1'b1);
    spin(12, 2'd1);
    push_tick(0, 0);
    spin(12, 2'd3);
    push_tick(0, 0);
    push_tick(0, 0);
    settle();

    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("dual_motor_encoder_pid_speed_unit: match");
    end else begin
      $display("dual_motor_encoder_pid_speed_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dmepid_pkg.sv
design/dmepid_lane.sv
design/dmepid_merge.sv
design/dual_motor_encoder_pid_speed_unit.sv
test/tb.sv
